[rtl/pcs_pkg.sv]
// ----------------------------------------------------------------------------
// pcs_pkg: shared types and helpers for the path component splitter
// byte classification, item and result records, sequencing phases
// ----------------------------------------------------------------------------
package pcs_pkg;

   localparam int NAME_LENGTH_DEF = 39;
   localparam int LEN_W           = 6;
   localparam int COUNT_W         = 8;

   localparam logic [7:0]         SEP_BYTE  = 8'h5C;
   localparam logic [7:0]         PAD_BYTE  = 8'h20;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_CLOSE,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] in_byte;
      logic       byte_present;
      logic       path_end;
   } item_type;

   typedef struct packed {
      logic [7:0]         out_byte;
      logic               out_byte_valid;
      logic               component_end;
      logic               path_done;
      logic               path_error;
      logic [COUNT_W-1:0] component_count;
      logic               run_last;
   } result_type;

   // fat illegal set: control codes, top half, and the reserved punctuation
   function automatic logic byte_illegal(input logic [7:0] b);
      logic bad;
      bad = (b < 8'h20) || (b >= 8'h80) ||
            (b inside {8'h22, 8'h2F, 8'h7C, [8'h2A:8'h2C], [8'h3A:8'h3F], [8'h5B:8'h5D]});
      return bad;
   endfunction

   // ascii-only uppercase
   function automatic logic [7:0] to_upper(input logic [7:0] b);
      logic [7:0] u;
      u = (b inside {[8'h61:8'h7A]}) ? (b - 8'h20) : b;
      return u;
   endfunction

endpackage

[rtl/pcs_in_reg.sv]
// ----------------------------------------------------------------------------
// pcs_in_reg: input holding register
// captures one path item and holds it until the engine has finished it
// ----------------------------------------------------------------------------
module pcs_in_reg
   import pcs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] in_byte,
   input  logic       byte_present,
   input  logic       path_end,
   input  logic       item_done,
   output item_type   item
);

   item_type item_ff;
   item_type item_in;
   logic     accept;

   assign req_tready = !item_ff.valid || item_done;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      item_in = item_ff;
      if (accept) begin
         item_in.valid        = 1'b1;
         item_in.in_byte      = in_byte;
         item_in.byte_present = byte_present;
         item_in.path_end     = path_end;
      end else if (item_done) begin
         item_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else begin
         item_ff.valid <= item_in.valid;
      end
      item_ff.in_byte      <= item_in.in_byte;
      item_ff.byte_present <= item_in.byte_present;
      item_ff.path_end     <= item_in.path_end;
   end

   assign item = item_ff;

endmodule

[rtl/pcs_engine.sv]
// ----------------------------------------------------------------------------
// pcs_engine: component splitting and name checking
// one step per cycle when out_free: name byte, pad byte, close marker or done
// ----------------------------------------------------------------------------
module pcs_engine
   import pcs_pkg::*;
#(
   parameter int NAME_LENGTH = NAME_LENGTH_DEF
)
(
   input  logic       clock,
   input  logic       reset,
   input  item_type   item,
   input  logic       out_free,
   output logic       item_done,
   output logic       emit,
   output result_type res
);

   localparam logic [LEN_W-1:0] NAME_LEN_C = LEN_W'(NAME_LENGTH);

   logic [LEN_W-1:0]   len_ff, len_in;
   logic               err_ff, err_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   phase_type          phase_ff, phase_in;

   logic               byte_act, is_sep, bad_byte;
   logic               close_empty, close_marker, close_finish;
   logic [LEN_W-1:0]   len_inc;
   logic [COUNT_W-1:0] cnt_sat;
   logic               take_close, take_done, set_err;

   assign byte_act     = item.byte_present && !err_ff;
   assign is_sep       = (item.in_byte == SEP_BYTE);
   assign bad_byte     = byte_illegal(item.in_byte) || (len_ff >= NAME_LEN_C);
   assign len_inc      = len_ff + LEN_W'(1);
   assign cnt_sat      = (cnt_ff == COUNT_MAX) ? cnt_ff : (cnt_ff + COUNT_W'(1));
   assign close_empty  = err_ff || (len_ff == '0);
   assign close_marker = (len_ff >= NAME_LEN_C);
   assign close_finish = close_marker || (len_inc == NAME_LEN_C);

   always_comb begin
      len_in     = len_ff;
      err_in     = err_ff;
      cnt_in     = cnt_ff;
      phase_in   = phase_ff;
      emit       = 1'b0;
      item_done  = 1'b0;
      take_close = 1'b0;
      take_done  = 1'b0;
      set_err    = 1'b0;
      res                 = '0;
      res.path_error      = err_ff;
      res.component_count = cnt_ff;

      if (item.valid && out_free) begin
         case (phase_ff)
            PH_FIRST: begin
               if (byte_act && !is_sep) begin
                  if (bad_byte) begin
                     set_err = 1'b1;
                     err_in  = 1'b1;
                     if (item.path_end) begin
                        take_done = 1'b1;
                     end else begin
                        item_done = 1'b1;
                     end
                  end else begin
                     emit               = 1'b1;
                     res.out_byte       = to_upper(item.in_byte);
                     res.out_byte_valid = 1'b1;
                     len_in             = len_inc;
                     if (item.path_end) begin
                        phase_in = PH_CLOSE;
                     end else begin
                        res.run_last = 1'b1;
                        item_done    = 1'b1;
                     end
                  end
               end else if (byte_act || item.path_end) begin
                  // separator, or bare end marker
                  take_close = 1'b1;
               end else begin
                  item_done = 1'b1;
               end
            end
            PH_CLOSE: take_close = 1'b1;
            PH_DONE:  take_done  = 1'b1;
            default:  take_done  = 1'b1;
         endcase

         if (take_close) begin
            if (close_empty) begin
               if (item.path_end) begin
                  take_done = 1'b1;
               end else begin
                  item_done = 1'b1;
               end
            end else begin
               emit               = 1'b1;
               res.out_byte       = close_marker ? 8'h00 : PAD_BYTE;
               res.out_byte_valid = !close_marker;
               res.component_end  = close_finish;
               if (close_finish) begin
                  len_in = '0;
                  cnt_in = cnt_sat;
                  if (item.path_end) begin
                     phase_in = PH_DONE;
                  end else begin
                     res.run_last = 1'b1;
                     item_done    = 1'b1;
                  end
               end else begin
                  len_in   = len_inc;
                  phase_in = PH_CLOSE;
               end
            end
         end

         if (take_done) begin
            emit               = 1'b1;
            res.out_byte       = 8'h00;
            res.out_byte_valid = 1'b0;
            res.component_end  = 1'b0;
            res.path_done      = 1'b1;
            res.path_error     = err_ff || set_err;
            res.run_last       = 1'b1;
            len_in             = '0;
            err_in             = 1'b0;
            cnt_in             = '0;
            item_done          = 1'b1;
         end

         if (item_done) begin
            phase_in = PH_FIRST;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         err_ff   <= 1'b0;
         cnt_ff   <= '0;
         phase_ff <= PH_FIRST;
      end else begin
         len_ff   <= len_in;
         err_ff   <= err_in;
         cnt_ff   <= cnt_in;
         phase_ff <= phase_in;
      end
   end

   // open component never outgrows the name field
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= NAME_LEN_C)
      else $error("component length beyond name length");

   // padding only runs on an error-free path
   a_close_no_err: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_CLOSE) |-> !err_ff)
      else $error("padding while error is set");

   // a done result returns the path state to its cleared values
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      (emit && res.path_done) |=> (len_ff == '0 && !err_ff && cnt_ff == '0))
      else $error("state not cleared after done result");

   // mid-item phases only while an item is held
   a_phase_item: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_FIRST) |-> item.valid)
      else $error("engine mid-item without a held item");

endmodule

[rtl/pcs_out_reg.sv]
// ----------------------------------------------------------------------------
// pcs_out_reg: result register
// holds one result transaction until the consumer takes it
// ----------------------------------------------------------------------------
module pcs_out_reg
   import pcs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       emit,
   input  result_type res,
   output logic       out_free,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output result_type rsp
);

   logic       valid_ff, valid_in;
   result_type rsp_ff, rsp_in;

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      rsp_in   = rsp_ff;
      if (emit) begin
         valid_in = 1'b1;
         rsp_in   = res;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp        = rsp_ff;

endmodule

[rtl/path_component_splitter.sv]
// ----------------------------------------------------------------------------
// path_component_splitter: fat path component splitter and name checker
// splits a backslash-separated path into upper-cased, space-padded names
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata                            | tuser / tlast
//  --------+-----------+----------------------------------+-----------------------
//  req     | in        | in_byte                          | byte_present / path_end
//  rsp     | out       | out_byte, path_error, comp count | byte flags / run_last
//
//  a name byte is one transaction in and one transaction out
//  closing a component emits one pad byte per missing byte (up to NAME_LENGTH - 1), or a
//  single marker transaction for a full name; the input is held during that run
//  a path end item adds one done transaction
//  reset clears length, error and count; no sweep is needed after reset
//  a stall on rsp holds the result register and backs up into req_tready
//
module path_component_splitter
   import pcs_pkg::*;
#(
   parameter int NAME_LENGTH = NAME_LENGTH_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   // input transaction
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] byte_present
   input  logic        req_tlast,   // path_end
   // result transaction
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] out_byte, [8] path_error,
                                    // [16:9] component_count, [23:17] zero
   output logic [2:0]  rsp_tuser,   // [0] out_byte_valid, [1] component_end,
                                    // [2] path_done
   output logic        rsp_tlast    // run_last
);

   item_type   item;
   logic       item_done;
   logic       out_free;
   logic       emit;
   result_type res;
   result_type rsp;

   // input holding register
   pcs_in_reg u_in_reg (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .in_byte      (req_tdata),
      .byte_present (req_tuser),
      .path_end     (req_tlast),
      .item_done    (item_done),
      .item         (item)
   );

   // splitting, checking and padding
   pcs_engine #(
      .NAME_LENGTH (NAME_LENGTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .item      (item),
      .out_free  (out_free),
      .item_done (item_done),
      .emit      (emit),
      .res       (res)
   );

   // result register
   pcs_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .emit       (emit),
      .res        (res),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp        (rsp)
   );

   // pack result fields onto the stream
   assign rsp_tdata = {7'b0, rsp.component_count, rsp.path_error, rsp.out_byte};
   assign rsp_tuser = {rsp.path_done, rsp.component_end, rsp.out_byte_valid};
   assign rsp_tlast = rsp.run_last;

endmodule

[test/path_component_splitter_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_component_splitter_tb: self-checking bench for the path splitter
// feeds backslash-separated byte paths over req, predicts the padded upper-case
// names, markers and done transactions, and checks every rsp transaction
// ----------------------------------------------------------------------------
module path_component_splitter_tb;
   import pcs_pkg::*;

   localparam int NAME_LEN       = NAME_LENGTH_DEF;
   localparam int RANDOM_ITEMS   = 135;          // includes the forced long path
   localparam int HOLD_CYCLES    = 400;          // long receiver back-pressure stretch
   localparam int SETTLE_CYCLES  = 3 * NAME_LEN; // longest padding run plus margin
   localparam int DRAIN_LIMIT    = 50000;
   localparam longint TIMEOUT_NS = 64'd6_400_000;

   // one queued req transaction, or a marker that pauses the sender until idle
   typedef struct packed {
      bit         drain;
      logic [7:0] in_byte;
      logic       present;
      logic       is_last;
   } path_item_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;  // [7:0] in_byte
   logic        req_tuser  = 1'b0; // [0] byte_present
   logic        req_tlast  = 1'b0; // path_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [7:0] out_byte, [8] path_error, [16:9] count, [23:17] zero
   logic [2:0]  rsp_tuser;        // [0] out_byte_valid, [1] component_end, [2] path_done
   logic        rsp_tlast;        // run_last

   // stimulus and expectation stores
   path_item_type path_items[$];
   result_type    name_results[$];
   result_type    name_batch[$];

   // predictor state, mirrors the block after reset
   logic [LEN_W-1:0]   name_len   = '0;
   bit                 name_err   = 1'b0;
   logic [COUNT_W-1:0] names_done = '0;

   // driver and monitor bookkeeping
   path_item_type drv_item    = '0;
   bit         sending        = 1'b0;
   int         send_gap       = 0;
   int         recv_gap       = 0;
   int         items_accepted = 0;
   int         results_seen   = 0;
   int         paths_seen     = 0;
   int         paths_flagged  = 0;
   int         stim_items     = 0;
   int         mismatches     = 0;
   logic       hold_rx        = 1'b0;

   path_component_splitter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------

   // bytes a fat short name may not hold; the separator is in the set too
   function automatic bit fat_reserved(input logic [7:0] b);
      if (b < 8'h20 || b[7])
         return 1'b1;
      case (b)
         8'h22, 8'h2A, 8'h2B, 8'h2C, 8'h2F,
         8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F,
         8'h5B, 8'h5C, 8'h5D, 8'h7C: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // a result carries the error flag and count as they stand when it is made
   function automatic result_type name_result(input logic [7:0] b, input logic bv,
                                              input logic ce, input logic pd);
      result_type r;
      r.out_byte        = b;
      r.out_byte_valid  = bv;
      r.component_end   = ce;
      r.path_done       = pd;
      r.path_error      = name_err;
      r.component_count = names_done;
      r.run_last        = 1'b0;
      return r;
   endfunction

   // pad the open name to full length, or mark it when already full
   task automatic close_name();
      int fill;
      if (name_err || name_len == 0)
         return;
      if (name_len >= NAME_LEN) begin
         name_batch.push_back(name_result(8'h00, 1'b0, 1'b1, 1'b0));
      end else begin
         for (fill = name_len + 1; fill <= NAME_LEN; fill++)
            name_batch.push_back(name_result(PAD_BYTE, 1'b1, fill == NAME_LEN, 1'b0));
      end
      name_len = '0;
      if (names_done != COUNT_MAX)
         names_done++;
   endtask

   task automatic split_path_byte(input path_item_type it);
      logic [7:0] up;
      result_type r;
      name_batch.delete();
      if (it.present && !name_err) begin
         if (it.in_byte == SEP_BYTE) begin
            close_name();
         end else if (fat_reserved(it.in_byte) || name_len >= NAME_LEN) begin
            name_err = 1'b1;
         end else begin
            up = (it.in_byte >= "a" && it.in_byte <= "z") ? (it.in_byte & 8'hDF) : it.in_byte;
            name_batch.push_back(name_result(up, 1'b1, 1'b0, 1'b0));
            name_len++;
         end
      end
      if (it.is_last) begin
         close_name();
         name_batch.push_back(name_result(8'h00, 1'b0, 1'b0, 1'b1));
         name_len   = '0;
         name_err   = 1'b0;
         names_done = '0;
      end
      // tlast goes on the final transaction this item causes
      foreach (name_batch[i]) begin
         r          = name_batch[i];
         r.run_last = (i == name_batch.size() - 1);
         name_results.push_back(r);
      end
   endtask

   // ------------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input int want, input int got);
      $display("mismatch @%0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
      mismatches++;
   endtask

   task automatic check_name_result();
      result_type want;
      if (name_results.size() == 0) begin
         report_mismatch("rsp transaction with nothing outstanding", 0, rsp_tdata);
         return;
      end
      want = name_results.pop_front();
      if (rsp_tdata[7:0] != want.out_byte)
         report_mismatch("out_byte", want.out_byte, rsp_tdata[7:0]);
      if (rsp_tuser[0] != want.out_byte_valid)
         report_mismatch("out_byte_valid", want.out_byte_valid, rsp_tuser[0]);
      if (rsp_tuser[1] != want.component_end)
         report_mismatch("component_end", want.component_end, rsp_tuser[1]);
      if (rsp_tuser[2] != want.path_done)
         report_mismatch("path_done", want.path_done, rsp_tuser[2]);
      if (rsp_tdata[8] != want.path_error)
         report_mismatch("path_error", want.path_error, rsp_tdata[8]);
      if (rsp_tdata[16:9] != want.component_count)
         report_mismatch("component_count", want.component_count, rsp_tdata[16:9]);
      if (rsp_tlast != want.run_last)
         report_mismatch("run_last", want.run_last, rsp_tlast);
      if (rsp_tdata[23:17] != '0)
         report_mismatch("tdata padding", 0, rsp_tdata[23:17]);
      if (want.path_done) begin
         paths_seen++;
         if (want.path_error)
            paths_flagged++;
      end
   endtask

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   task automatic push_byte(input logic [7:0] b, input logic is_last = 1'b0);
      path_items.push_back('{drain: 1'b0, in_byte: b, present: 1'b1, is_last: is_last});
      stim_items++;
   endtask

   // bare end marker, no byte with it
   task automatic push_end();
      path_items.push_back('{drain: 1'b0, in_byte: 8'($urandom_range(0, 255)), present: 1'b0,
                             is_last: 1'b1});
      stim_items++;
   endtask

   // empty transaction, the block should stay silent
   task automatic push_idle_item();
      path_items.push_back('{drain: 1'b0, in_byte: 8'($urandom_range(0, 255)), present: 1'b0,
                             is_last: 1'b0});
   endtask

   // sender holds off here until every outstanding result has arrived
   task automatic push_drain();
      path_items.push_back('{drain: 1'b1, in_byte: 8'h00, present: 1'b0, is_last: 1'b0});
   endtask

   function automatic logic [7:0] legal_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(8'h20, 8'h7F));
      while (fat_reserved(b));
      return b;
   endfunction

   function automatic logic [7:0] reserved_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while (!fat_reserved(b) || b == SEP_BYTE);
      return b;
   endfunction

   // one path; lens[] fixes the name lengths when non-empty, else they are drawn
   task automatic push_path(input int lens[$]);
      int parts, len, k, j, ending, pick;
      bit mangled;
      logic mark;
      mangled = ($urandom_range(0, 9) == 0);
      parts   = (lens.size() > 0) ? lens.size() : $urandom_range(1, 4);
      ending  = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0)
         push_byte(SEP_BYTE);
      for (k = 0; k < parts; k++) begin
         if (lens.size() > 0) begin
            len = lens[k];
         end else begin
            pick = $urandom_range(0, 19);
            len  = (pick == 0) ? NAME_LEN - 1 : (pick == 1) ? NAME_LEN :
                   (pick == 2) ? NAME_LEN + 1 : $urandom_range(1, 8);
         end
         for (j = 0; j < len; j++) begin
            mark = (ending == 0 && k == parts - 1 && j == len - 1);
            if (mangled)
               push_byte(8'($urandom_range(0, 255)), mark);
            else if ($urandom_range(0, 99) == 0)
               push_byte(reserved_byte(), mark);
            else
               push_byte(legal_byte(), mark);
            if ($urandom_range(0, 15) == 0)
               push_idle_item();
         end
         if (k < parts - 1)
            repeat ($urandom_range(1, 2)) push_byte(SEP_BYTE);
      end
      case (ending)
         1: push_byte(SEP_BYTE, 1'b1);
         2: push_end();
         3: begin
            push_byte(SEP_BYTE);
            push_end();
         end
         default: ;
      endcase
   endtask

   function automatic int pick_gap(input int n);
      // every third stretch of fifty transactions runs with no idling at all
      return ((n / 50) % 3 == 1) ? 0 : $urandom_range(0, 3);
   endfunction

   // ------------------------------------------------------------------------
   // req driver: pops queued items, predicts each one as it is accepted
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         sending  = 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            split_path_byte(drv_item);
            items_accepted++;
            sending  = 1'b0;
            send_gap = pick_gap(items_accepted);
         end
         if (!sending) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (path_items.size() > 0) begin
               if (path_items[0].drain) begin
                  if (name_results.size() == 0)
                     path_items.delete(0);
               end else begin
                  drv_item = path_items.pop_front();
                  sending  = 1'b1;
               end
            end
         end
         // a single assignment per edge keeps tvalid high across back-to-back items
         req_tvalid <= sending;
         req_tdata  <= drv_item.in_byte;
         req_tuser  <= drv_item.present;
         req_tlast  <= drv_item.is_last;
      end
   end

   // ------------------------------------------------------------------------
   // rsp monitor: random ready gaps, long hold-off on request
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_name_result();
            results_seen++;
            recv_gap = pick_gap(results_seen);
         end
         if (hold_rx) begin
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // long receiver stall while the sender keeps offering, so req backs up
   initial begin
      while (items_accepted < 40) @(posedge clock);
      hold_rx <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rx <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      int lens[$];
      int settle;

      // lower case letters, then a separator closes the name
      push_byte("a");
      push_byte("b");
      push_byte(SEP_BYTE);
      // separator run, then an empty transaction
      push_byte(SEP_BYTE);
      push_byte(SEP_BYTE);
      push_idle_item();
      // legal edges of the byte range, path end riding on a byte
      push_byte(8'h20);
      push_byte("{");
      push_byte(8'h7F);
      push_byte("~", 1'b1);
      push_drain();
      // illegal control byte mid name: later bytes and separators go silent
      push_byte("q");
      push_byte(8'h00);
      push_byte("r");
      push_byte(SEP_BYTE);
      push_end();
      // illegal top byte on the end item itself
      push_byte(8'hFF, 1'b1);
      // reserved punctuation, then a byte that must be suppressed
      push_byte(8'h3A);
      push_byte("z", 1'b1);
      // empty path
      push_end();
      // separator carrying the path end
      push_byte("!");
      push_byte(SEP_BYTE, 1'b1);
      push_drain();

      // full name, one short of full, then an overlong name
      stim_items = 0;
      lens = '{NAME_LEN, NAME_LEN - 1, NAME_LEN + 1};
      push_path(lens);
      lens.delete();
      while (stim_items < RANDOM_ITEMS)
         push_path(lens);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (path_items.size() > 0 || sending) @(posedge clock);
      settle = 0;
      while (name_results.size() > 0 && settle < DRAIN_LIMIT) begin
         @(posedge clock);
         settle++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (name_results.size() > 0)
         report_mismatch("rsp transactions never delivered", 0, name_results.size());

      $display("covered %0d req transactions and %0d rsp transactions over %0d paths",
               items_accepted, results_seen, paths_seen);
      $display("%0d paths flagged in error, long name and reserved byte cases",
               paths_flagged);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("timeout with %0d results outstanding", name_results.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
